### rtl/ssm_pkg.sv
// Shared types and constants for the sparse set slot map.
`default_nettype none

package ssm_pkg;

    // Fixed field widths
    localparam int ID_W       = 32;
    localparam int OP_W       = 2;
    localparam int EB_W       = 9;
    localparam int OFFSET_W   = 19;
    localparam int LIVE_W     = 11;
    // Wide enough for any sparse index (INDEX_BITS up to 16) and its bound
    localparam int WIDE_IDX_W = 17;

    localparam logic [EB_W-1:0] EB_RESET = 9'd4;

    // Defaults for the top level parameters
    localparam int DEF_NUM_SLOTS  = 1024;
    localparam int DEF_INDEX_BITS = 10;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_HAS    = 2'd1,
        OP_GET    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_FIX
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step; // invalidate one sparse entry
        logic take;       // capture input beat, issue sparse and last-dense reads
        logic lookup;     // latch last dense id, read dense at mapped slot
        logic commit;     // decide, write tables, load result
        logic fix;        // remap the moved id's index
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass is on its final entry
        logic fix_needed;  // remove moved an entry whose index needs remapping
        logic result_busy; // result register full and stalled
    } status_t;

endpackage

`default_nettype wire

### rtl/ssm_ctrl.sv
// Control state machine for the sparse set slot map.
`default_nettype none

module ssm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  ssm_pkg::status_t     status,
    output ssm_pkg::cmd_t        cmd
);
    import ssm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // wait for the result register to drain
                if (!status.result_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = status.fix_needed ? ST_FIX : ST_IDLE;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ssm_datapath.sv
// Datapath of the sparse set slot map: tables, count, offsets and result register.
`default_nettype none

module ssm_datapath #(
    parameter int NUM_SLOTS  = ssm_pkg::DEF_NUM_SLOTS,
    parameter int INDEX_BITS = ssm_pkg::DEF_INDEX_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ssm_pkg::EB_W-1:0]      cfg_wdata,
    input  wire logic [ssm_pkg::OP_W-1:0]      operation,
    input  wire logic [ssm_pkg::ID_W-1:0]      entity_id,
    input  ssm_pkg::cmd_t                      cmd,
    output ssm_pkg::status_t                   status,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic                               stale,
    output logic [ssm_pkg::OFFSET_W-1:0]       data_offset,
    output logic                               do_move,
    output logic [ssm_pkg::OFFSET_W-1:0]       move_from_offset,
    output logic [ssm_pkg::LIVE_W-1:0]         live_count
);
    import ssm_pkg::*;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int COUNT_W = $clog2(NUM_SLOTS + 1);
    localparam int PROD_W  = COUNT_W + EB_W;

    localparam logic [SLOT_W-1:0]     LAST_ADDR = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [COUNT_W-1:0]    COUNT_MAX = COUNT_W'(NUM_SLOTS);
    localparam logic [WIDE_IDX_W-1:0] IDX_LIMIT = WIDE_IDX_W'(NUM_SLOTS);

    // Tables: sparse word is {mapped, slot}
    logic [SLOT_W:0]   sparse_mem_reg [NUM_SLOTS];
    logic [ID_W-1:0]   dense_mem_reg  [NUM_SLOTS];
    logic [SLOT_W:0]   sparse_rd_reg;
    logic [ID_W-1:0]   dense_rd_reg;

    // Control and item registers
    logic [EB_W-1:0]    eb_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [SLOT_W-1:0]  clr_addr_reg;
    op_t                op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    moved_reg;

    // Result register
    logic                out_valid_reg;
    logic                ok_reg;
    logic                stale_reg;
    logic [OFFSET_W-1:0] data_off_reg;
    logic                move_reg;
    logic [OFFSET_W-1:0] from_off_reg;
    logic [LIVE_W-1:0]   live_reg;

    // Index decode
    logic [WIDE_IDX_W-1:0] in_idx_wide;
    logic [WIDE_IDX_W-1:0] idx_wide;
    logic [WIDE_IDX_W-1:0] midx_wide;
    logic                  idx_in_range;
    logic                  midx_in_range;

    // Lookup decision
    logic               mapped;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] slot_ext;
    logic [COUNT_W-1:0] last;
    logic               match;
    logic               add_ok;
    logic               find_ok;
    logic               rem_ok;
    logic               move;
    logic               res_ok;
    logic [COUNT_W-1:0] pos;
    logic [PROD_W-1:0]  pos_prod;
    logic [PROD_W-1:0]  last_prod;

    // Memory port controls
    logic              sp_we;
    logic              sp_re;
    logic [SLOT_W-1:0] sp_addr;
    logic [SLOT_W:0]   sp_wdata;
    logic              dn_we;
    logic              dn_re;
    logic [SLOT_W-1:0] dn_addr;
    logic [ID_W-1:0]   dn_wdata;

    assign in_idx_wide   = WIDE_IDX_W'(entity_id[INDEX_BITS-1:0]);
    assign idx_wide      = WIDE_IDX_W'(id_reg[INDEX_BITS-1:0]);
    assign midx_wide     = WIDE_IDX_W'(moved_reg[INDEX_BITS-1:0]);
    assign idx_in_range  = idx_wide < IDX_LIMIT;
    assign midx_in_range = midx_wide < IDX_LIMIT;

    assign mapped   = sparse_rd_reg[SLOT_W];
    assign slot     = sparse_rd_reg[SLOT_W-1:0];
    assign slot_ext = COUNT_W'(slot);
    assign last     = count_reg - COUNT_W'(1);
    assign match    = mapped && (dense_rd_reg == id_reg);

    assign add_ok  = idx_in_range && (op_reg == OP_ADD) && !mapped && (count_reg < COUNT_MAX);
    assign find_ok = idx_in_range && match && ((op_reg == OP_HAS) || (op_reg == OP_GET));
    assign rem_ok  = idx_in_range && match && (op_reg == OP_REMOVE)
                     && (count_reg != '0);
    assign move    = rem_ok && (slot_ext != last);
    assign res_ok  = add_ok || find_ok || rem_ok;

    // Byte offsets
    assign pos       = add_ok ? count_reg : slot_ext;
    assign pos_prod  = PROD_W'(pos) * PROD_W'(eb_reg);
    assign last_prod = PROD_W'(last) * PROD_W'(eb_reg);

    always_comb
    begin
        count_next = count_reg;
        if (add_ok)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (rem_ok)
        begin
            count_next = last;
        end
    end

    // Sparse port selection
    always_comb
    begin
        sp_we    = 1'b0;
        sp_re    = 1'b0;
        sp_addr  = idx_wide[SLOT_W-1:0];
        sp_wdata = '0;
        if (cmd.clear_step)
        begin
            sp_we   = 1'b1;
            sp_addr = clr_addr_reg;
        end
        else if (cmd.take)
        begin
            sp_re   = 1'b1;
            sp_addr = in_idx_wide[SLOT_W-1:0];
        end
        else if (cmd.commit)
        begin
            sp_we    = add_ok || rem_ok;
            sp_wdata = add_ok ? {1'b1, count_reg[SLOT_W-1:0]} : '0;
        end
        else if (cmd.fix)
        begin
            sp_we    = 1'b1;
            sp_addr  = midx_wide[SLOT_W-1:0];
            sp_wdata = {1'b1, slot};
        end
    end

    // Dense port selection
    always_comb
    begin
        dn_we    = 1'b0;
        dn_re    = 1'b0;
        dn_addr  = slot;
        dn_wdata = moved_reg;
        if (cmd.take)
        begin
            dn_re   = 1'b1;
            dn_addr = last[SLOT_W-1:0];
        end
        else if (cmd.lookup)
        begin
            dn_re = 1'b1;
        end
        else if (cmd.commit)
        begin
            if (add_ok)
            begin
                dn_we    = 1'b1;
                dn_addr  = count_reg[SLOT_W-1:0];
                dn_wdata = id_reg;
            end
            else if (move)
            begin
                dn_we = 1'b1;
            end
        end
    end

    // Sparse table
    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sparse_mem_reg[sp_addr] <= sp_wdata;
        end
        else if (sp_re)
        begin
            sparse_rd_reg <= sparse_mem_reg[sp_addr];
        end
    end

    // Dense table
    always_ff @(posedge clk)
    begin
        if (dn_we)
        begin
            dense_mem_reg[dn_addr] <= dn_wdata;
        end
        else if (dn_re)
        begin
            dense_rd_reg <= dense_mem_reg[dn_addr];
        end
    end

    // Item and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg <= op_t'(operation);
            id_reg <= entity_id;
        end
        // dense read issued at take returns the last entry
        if (cmd.lookup)
        begin
            moved_reg <= dense_rd_reg;
        end
        if (cmd.commit)
        begin
            ok_reg       <= res_ok;
            stale_reg    <= idx_in_range && mapped && !match;
            data_off_reg <= res_ok ? OFFSET_W'(pos_prod) : '0;
            move_reg     <= move;
            from_off_reg <= move ? OFFSET_W'(last_prod) : '0;
            live_reg     <= LIVE_W'(count_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eb_reg        <= EB_RESET;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                eb_reg <= cfg_wdata;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
            end
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last  = clr_addr_reg == LAST_ADDR;
    assign status.fix_needed  = move && midx_in_range;
    assign status.result_busy = out_valid_reg && out_stall;

    assign out_valid        = out_valid_reg;
    assign ok               = ok_reg;
    assign stale            = stale_reg;
    assign data_offset      = data_off_reg;
    assign do_move          = move_reg;
    assign move_from_offset = from_off_reg;
    assign live_count       = live_reg;

endmodule

`default_nettype wire

### rtl/sparse_set_slot_map.sv
// Top level of the sparse set slot map: controller, datapath and checks.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------
//  in       | in_valid / in_stall      | operation, entity_id
//  out      | out_valid / out_stall    | ok, stale, data_offset, do_move,
//           |                          | move_from_offset, live_count
//  cfg      | cfg_we                   | cfg_wdata (element_bytes)
//
// An item goes from its accept through LOOKUP and CHECK before the next accept, and a
// remove that moves the last entry also through FIX, set by the single-port sparse and
// dense tables. After reset the sparse table is cleared one entry a cycle with
// in_stall high. A result beat waits in the output register; the next item may be
// taken meanwhile and holds before its commit until that beat leaves.
`default_nettype none

module sparse_set_slot_map #(
    parameter int NUM_SLOTS  = ssm_pkg::DEF_NUM_SLOTS,
    parameter int INDEX_BITS = ssm_pkg::DEF_INDEX_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ssm_pkg::EB_W-1:0]      cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ssm_pkg::OP_W-1:0]      operation,
    input  wire logic [ssm_pkg::ID_W-1:0]      entity_id,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic                               stale,
    output logic [ssm_pkg::OFFSET_W-1:0]       data_offset,
    output logic                               do_move,
    output logic [ssm_pkg::OFFSET_W-1:0]       move_from_offset,
    output logic [ssm_pkg::LIVE_W-1:0]         live_count
);
    import ssm_pkg::*;

    cmd_t    cmd;
    status_t status;

    ssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ssm_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .operation        (operation),
        .entity_id        (entity_id),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .ok               (ok),
        .stale            (stale),
        .data_offset      (data_offset),
        .do_move          (do_move),
        .move_from_offset (move_from_offset),
        .live_count       (live_count)
    );

    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    // A commit never overwrites a stalled result beat
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("commit while result register is stalled");

    // A remap step only follows a commit
    a_fix_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fix |-> $past(cmd.commit))
        else $error("remap without preceding commit");

    // Once a beat is accepted the input is closed until the item is done
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open directly after accepting a beat");

endmodule

`default_nettype wire
